// File: src/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and the round mixing function for the TEA datapath.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KEY_CNT = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3 = 2'd3;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [KEY_CNT-1:0] key_t;

  // block in flight between two cells
  typedef struct packed {
    logic  mode;
    word_t y;
    word_t z;
  } tea_beat_t;

  function automatic word_t tea_mix(input word_t v, input word_t s,
                                    input word_t a, input word_t b);
    word_t left;
    word_t mid;
    word_t right;
    left  = (v << 4) + a;
    mid   = v + s;
    right = (v >> 5) + b;
    return left ^ mid ^ right;
  endfunction

endpackage

// File: src/tea_in_if.sv
// ----------------------------------------------------------------------------
// tea_in_if
// Input channel: one plaintext or ciphertext block with its mode bit.
// ----------------------------------------------------------------------------
interface tea_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] first_word;
  logic [31:0] second_word;

  modport source (output valid, output mode, output first_word, output second_word,
                  input ready);
  modport sink   (input valid, input mode, input first_word, input second_word,
                  output ready);
endinterface

// File: src/tea_out_if.sv
// ----------------------------------------------------------------------------
// tea_out_if
// Output channel: one transformed block.
// ----------------------------------------------------------------------------
interface tea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_result;
  logic [31:0] second_result;

  modport source (output valid, output first_result, output second_result,
                  input ready);
  modport sink   (input valid, input first_result, input second_result,
                  output ready);
endinterface

// File: src/tea_cell.sv
// ----------------------------------------------------------------------------
// tea_cell
// One half-round of TEA with its own stage register. Direction of the
// update (add for encrypt, subtract for decrypt) follows the beat's mode.
// ----------------------------------------------------------------------------
module tea_cell
  import tea_pkg::*;
#(
  parameter logic [31:0] ENC_SUM = 32'h0,
  parameter logic [31:0] DEC_SUM = 32'h0,
  parameter bit          HALF    = 1'b0
) (
  input  logic      clk,
  input  logic      rst,
  input  key_t      keys,
  input  logic      prev_valid,
  output logic      prev_ready,
  input  tea_beat_t prev_beat,
  output logic      valid,
  input  logic      next_ready,
  output tea_beat_t beat
);

  logic      upd_y;
  word_t     sum;
  word_t     src;
  word_t     tgt;
  word_t     key_a;
  word_t     key_b;
  word_t     f;
  word_t     tgt_next;
  tea_beat_t beat_next;

  // encrypt first half and decrypt second half both update y from z
  assign upd_y = (prev_beat.mode == HALF);
  assign sum   = prev_beat.mode ? DEC_SUM : ENC_SUM;
  assign src   = upd_y ? prev_beat.z : prev_beat.y;
  assign tgt   = upd_y ? prev_beat.y : prev_beat.z;
  assign key_a = upd_y ? keys[0] : keys[2];
  assign key_b = upd_y ? keys[1] : keys[3];
  assign f     = tea_mix(src, sum, key_a, key_b);
  assign tgt_next = prev_beat.mode ? (tgt - f) : (tgt + f);

  always_comb begin
    beat_next = prev_beat;
    if (upd_y) begin
      beat_next.y = tgt_next;
    end else begin
      beat_next.z = tgt_next;
    end
  end

  assign prev_ready = !valid || next_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (prev_ready) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prev_ready && prev_valid) begin
      beat <= beat_next;
    end
  end

endmodule

// File: src/tea_block_cipher_8round.sv
// ----------------------------------------------------------------------------
// tea_block_cipher_8round
// Reduced-round TEA encrypt/decrypt engine, one block per beat.
// ----------------------------------------------------------------------------
// The datapath is a chain of 2*ROUNDS cells, one per half-round, each with its
// own register, so the sustained rate is one block per cycle while the output
// is not stalled. Every cell has its own handshake stage, so bubbles close up
// while the output is stalled and input is taken as long as any stage of the
// chain is free. The four key words are written through the cfg port and must
// only change while no block is in flight.
module tea_block_cipher_8round
  import tea_pkg::*;
#(
  parameter int unsigned ROUNDS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  tea_in_if.sink               blk_in,
  tea_out_if.source            blk_out
);

  localparam int unsigned STAGES = 2 * ROUNDS;

  key_t      keys;
  logic      v     [STAGES+1];
  logic      rdy   [STAGES+1];
  tea_beat_t beats [STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_KEY0: keys[0] <= cfg_data;
        CFG_KEY1: keys[1] <= cfg_data;
        CFG_KEY2: keys[2] <= cfg_data;
        CFG_KEY3: keys[3] <= cfg_data;
        default:  keys    <= keys;
      endcase
    end
  end

  assign v[0]          = blk_in.valid;
  assign beats[0].mode = blk_in.mode;
  assign beats[0].y    = blk_in.first_word;
  assign beats[0].z    = blk_in.second_word;
  assign blk_in.ready  = rdy[0];

  for (genvar j = 0; j < STAGES; j++) begin : g_cell
    // round sums are fixed per cell
    localparam int unsigned RND = j / 2;
    localparam logic [31:0] ENC = 32'(64'(TEA_DELTA) * 64'(RND + 1));
    localparam logic [31:0] DEC = 32'(64'(TEA_DELTA) * 64'(ROUNDS - RND));

    tea_cell #(
      .ENC_SUM(ENC),
      .DEC_SUM(DEC),
      .HALF   (1'((j % 2)))
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .keys      (keys),
      .prev_valid(v[j]),
      .prev_ready(rdy[j]),
      .prev_beat (beats[j]),
      .valid     (v[j+1]),
      .next_ready(rdy[j+1]),
      .beat      (beats[j+1])
    );
  end

  assign rdy[STAGES]           = blk_out.ready;
  assign blk_out.valid         = v[STAGES];
  assign blk_out.first_result  = beats[STAGES].y;
  assign blk_out.second_result = beats[STAGES].z;

  // an empty first cell always takes a beat
  a_first_free: assert property (@(posedge clk) disable iff (rst)
    !v[1] |-> blk_in.ready)
    else $error("input stalled with first cell empty");

  // an accepted beat lands in the first cell
  a_first_load: assert property (@(posedge clk) disable iff (rst)
    blk_in.valid && blk_in.ready |=> v[1])
    else $error("accepted beat lost at first cell");

  // a stalled last cell holds its block
  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    blk_out.valid && !blk_out.ready |=> blk_out.valid && $stable(beats[STAGES]))
    else $error("stalled result changed");

  // key words move only on a write
  a_key_stable: assert property (@(posedge clk) disable iff (rst)
    !cfg_wr_en |=> $stable(keys))
    else $error("key changed without a write");

endmodule

// File: sim/tea_block_cipher_8round_tb.sv
// ----------------------------------------------------------------------------
// tea_block_cipher_8round_tb
// Streams encrypt and decrypt blocks through the reduced-round TEA engine under
// several key settings, with random gaps on the input and random stalls on the
// output. Every result is checked against a round-by-round prediction.
// ----------------------------------------------------------------------------
module tea_block_cipher_8round_tb;
  import tea_pkg::*;

  localparam int unsigned NUM_ROUNDS    = 8;
  localparam int unsigned PIPE_DEPTH    = 2 * NUM_ROUNDS;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_BLOCKS  = 305;
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;
  localparam logic [CFG_IDX_W-1:0] KEY_REGS [KEY_CNT] = '{CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3};

  class cipher_scoreboard;
    word_t       key_words [KEY_CNT];
    word_t       want_first [$];
    word_t       want_second [$];
    int unsigned errors;
    int unsigned blocks_in;
    int unsigned decrypts;
    int unsigned results_seen;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      errors       = 0;
      blocks_in    = 0;
      decrypts     = 0;
      results_seen = 0;
    endfunction

    function void set_key(input logic [CFG_IDX_W-1:0] idx, input word_t value);
      key_words[idx] = value;
    endfunction

    function int unsigned pending();
      return want_first.size();
    endfunction

    function word_t half_round(input word_t v, input word_t s, input word_t a, input word_t b);
      return ((v << 4) + a) ^ (v + s) ^ ((v >> 5) + b);
    endfunction

    function void transform(input logic m, input word_t y_in, input word_t z_in,
                            output word_t y_out, output word_t z_out);
      word_t y;
      word_t z;
      word_t sum;
      int    r;
      y = y_in;
      z = z_in;
      if (m == MODE_ENC) begin
        sum = '0;
        for (r = 0; r < NUM_ROUNDS; r++) begin
          sum = sum + TEA_DELTA;
          y   = y + half_round(z, sum, key_words[0], key_words[1]);
          z   = z + half_round(y, sum, key_words[2], key_words[3]);
        end
      end else begin
        // decrypt starts from the sum the last encrypt round used
        sum = TEA_DELTA * word_t'(NUM_ROUNDS);
        for (r = 0; r < NUM_ROUNDS; r++) begin
          z   = z - half_round(y, sum, key_words[2], key_words[3]);
          y   = y - half_round(z, sum, key_words[0], key_words[1]);
          sum = sum - TEA_DELTA;
        end
      end
      y_out = y;
      z_out = z;
    endfunction

    function void note_block(input logic m, input word_t y, input word_t z);
      word_t ry;
      word_t rz;
      transform(m, y, z, ry, rz);
      want_first.push_back(ry);
      want_second.push_back(rz);
      blocks_in++;
      if (m == MODE_DEC) decrypts++;
    endfunction

    task report(input string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_result(input word_t got_first, input word_t got_second);
      word_t exp_first;
      word_t exp_second;
      results_seen++;
      if (want_first.size() == 0) begin
        report($sformatf("unexpected result %08h %08h", got_first, got_second));
      end else begin
        exp_first  = want_first.pop_front();
        exp_second = want_second.pop_front();
        if (got_first !== exp_first)
          report($sformatf("result %0d first_result %08h, want %08h",
                           results_seen, got_first, exp_first));
        if (got_second !== exp_second)
          report($sformatf("result %0d second_result %08h, want %08h",
                           results_seen, got_second, exp_second));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  word_t                cfg_data;

  tea_in_if  blk_in_ch ();
  tea_out_if blk_out_ch ();

  cipher_scoreboard sb;
  bit               gaps_on  = 1'b1;
  bit               stalls_on = 1'b1;
  int unsigned      quiet_cycles;
  int unsigned      key_settings;

  tea_block_cipher_8round #(
    .ROUNDS(NUM_ROUNDS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .blk_in   (blk_in_ch),
    .blk_out  (blk_out_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, 31);
      3:       return ~(word_t'(1) << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  task automatic write_keys(input key_t keys, input logic [KEY_CNT-1:0] sel);
    for (int i = 0; i < KEY_CNT; i++) begin
      if (sel[i]) begin
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= KEY_REGS[i];
        cfg_data  <= keys[i];
        sb.set_key(KEY_REGS[i], keys[i]);
      end
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    key_settings++;
  endtask

  task automatic send_block(input logic m, input word_t y, input word_t z);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      blk_in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    blk_in_ch.valid       <= 1'b1;
    blk_in_ch.mode        <= m;
    blk_in_ch.first_word  <= y;
    blk_in_ch.second_word <= z;
    @(posedge clk);
    while (!blk_in_ch.ready) @(posedge clk);
    sb.note_block(m, y, z);
  endtask

  // encrypt a block, then decrypt the predicted ciphertext (or the other way)
  task automatic send_round_trip(input logic m, input word_t y, input word_t z);
    word_t cy;
    word_t cz;
    sb.transform(m, y, z, cy, cz);
    send_block(m, y, z);
    send_block(~m, cy, cz);
  endtask

  task automatic settle();
    blk_in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_block(MODE_ENC, 32'h0000_0000, 32'h0000_0000);
    send_block(MODE_DEC, 32'h0000_0000, 32'h0000_0000);
    send_block(MODE_ENC, 32'hffff_ffff, 32'hffff_ffff);
    send_block(MODE_DEC, 32'hffff_ffff, 32'hffff_ffff);
    send_block(MODE_ENC, 32'h8000_0000, 32'h0000_0001);
    send_block(MODE_DEC, 32'h0000_0001, 32'h8000_0000);
    send_block(MODE_ENC, 32'haaaa_aaaa, 32'h5555_5555);
    send_block(MODE_DEC, 32'h5555_5555, 32'haaaa_aaaa);
    send_block(MODE_ENC, 32'hffff_ffff, 32'h0000_0000);
    send_block(MODE_DEC, 32'h0000_0000, 32'hffff_ffff);
    send_round_trip(MODE_ENC, 32'h0123_4567, 32'h89ab_cdef);
  endtask

  // sink side: random stall bursts on ready
  initial begin
    blk_out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        blk_out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      blk_out_ch.ready <= 1'b1;
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (blk_out_ch.valid && blk_out_ch.ready)
        sb.check_result(blk_out_ch.first_result, blk_out_ch.second_result);
      if ((blk_in_ch.valid && blk_in_ch.ready) || (blk_out_ch.valid && blk_out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: %0d results still pending", sb.pending());
        $display("tea_block_cipher_8round verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    key_t        keys;
    logic [KEY_CNT-1:0] sel;
    word_t       y;
    word_t       z;
    int unsigned n;
    sb           = new();
    key_settings = 0;
    rst                   <= 1'b1;
    cfg_wr_en             <= 1'b0;
    cfg_index             <= CFG_KEY0;
    cfg_data              <= '0;
    blk_in_ch.valid       <= 1'b0;
    blk_in_ch.mode        <= MODE_ENC;
    blk_in_ch.first_word  <= '0;
    blk_in_ch.second_word <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset key of all zeros, then all ones
    run_directed();
    settle();
    write_keys('1, '1);
    run_directed();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      gaps_on   = (p != RANDOM_PHASES - 1);
      stalls_on = (p != RANDOM_PHASES - 1);
      for (int i = 0; i < KEY_CNT; i++)
        keys[i] = (p % 3 == 0) ? word_t'($urandom()) : pick_word();
      // every third setting rewrites a single key word only
      sel = (p % 3 == 2) ? (KEY_CNT'(1) << $urandom_range(0, KEY_CNT - 1)) : '1;
      write_keys(keys, sel);
      n = 0;
      while (n < PHASE_BLOCKS) begin
        y = pick_word();
        z = pick_word();
        if ($urandom_range(0, 9) < 6) begin
          send_round_trip(logic'($urandom_range(0, 1)), y, z);
          n += 2;
        end else begin
          send_block(logic'($urandom_range(0, 1)), y, z);
          n++;
        end
      end
    end

    settle();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    $display("ran %0d blocks (%0d decrypt) under %0d key settings, %0d results checked",
             sb.blocks_in, sb.decrypts, key_settings + 1, sb.results_seen);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tea_block_cipher_8round verification clean");
    end else begin
      $display("tea_block_cipher_8round verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/tea_pkg.sv
src/tea_in_if.sv
src/tea_out_if.sv
src/tea_cell.sv
src/tea_block_cipher_8round.sv
sim/tea_block_cipher_8round_tb.sv
